/* rtl/core/twr_pkg.sv */
// Shared types, codes and reset constants for the windowed TFTP receiver.
package twr_pkg;

  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ERROR = 16'd5;

  localparam logic [1:0] CFG_BLOCK_SIZE  = 2'd0;
  localparam logic [1:0] CFG_WINDOW_SIZE = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd2;

  localparam logic [15:0] BLOCK_SIZE_RST  = 16'd512;
  localparam logic [15:0] WINDOW_SIZE_RST = 16'd1;
  localparam logic [7:0]  RETRY_LIMIT_RST = 8'd6;

  localparam logic [1:0] ACK_NONE  = 2'd0;
  localparam logic [1:0] ACK_ONE   = 2'd1;
  localparam logic [1:0] ACK_FINAL = 2'd3;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [2:0] {
    ST_RUNNING    = 3'd0,
    ST_COMPLETE   = 3'd1,
    ST_TIMEOUT    = 3'd2,
    ST_PEER_ERROR = 3'd3,
    ST_UNEXPECTED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_TIMEOUT = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_t;

  // One classified event as it travels from the front end to the back end.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] blk;
    logic [15:0] size;
    logic        is_short;
  } cmd_t;

endpackage

/* rtl/core/twr_front.sv */
// Front end: classifies each incoming event and clips the payload length.
module twr_front (
  input  logic           in_func,
  input  logic [15:0]    in_pkt_opcode,
  input  logic [15:0]    in_pkt_block,
  input  logic [15:0]    in_payload_len,
  input  logic [15:0]    block_size,
  output twr_pkg::cmd_t  cmd
);
  import twr_pkg::*;

  logic [15:0] size;

  // A payload longer than the negotiated block is cut to the block size.
  assign size = (in_payload_len > block_size) ? block_size : in_payload_len;

  always_comb begin
    cmd.blk      = in_pkt_block;
    cmd.size     = size;
    cmd.is_short = (size != block_size);
    if (in_func) begin
      cmd.kind = KIND_TIMEOUT;
    end else begin
      unique case (in_pkt_opcode)
        OP_DATA:  cmd.kind = KIND_DATA;
        OP_ERROR: cmd.kind = KIND_ERROR;
        default:  cmd.kind = KIND_OTHER;
      endcase
    end
  end

endmodule

/* rtl/core/twr_queue.sv */
// Short command queue between the front end and the back end.
module twr_queue #(
  parameter int DEPTH = twr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  twr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output twr_pkg::cmd_t q_cmd
);
  import twr_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  cmd_t          entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/core/twr_back.sv */
// Back end: transfer state, window and retry tracking, and the result register.
module twr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  twr_pkg::cmd_t     q_cmd,
  output logic              pop,
  input  logic [15:0]       window_size,
  input  logic [7:0]        retry_limit,
  input  logic              retry_reload,
  input  logic [7:0]        retry_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_ack_copies,
  output logic [15:0]       out_ack_block,
  output logic [2:0]        out_status,
  output logic [31:0]       out_bytes_total
);
  import twr_pkg::*;

  logic [15:0] expected_r, expected_nxt;
  logic [16:0] window_r, window_nxt;
  logic [7:0]  retries_r, retries_nxt;
  logic        draining_r, draining_nxt;
  logic [31:0] bytes_r, bytes_nxt;
  status_t     status_r, status_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  copies_r, copies_nxt;
  logic [15:0] ack_r, ack_nxt;
  logic [32:0] sum;

  assign pop       = q_valid && (!out_valid_r || !out_stall);
  assign sum       = {1'b0, bytes_r} + {17'd0, q_cmd.size};

  always_comb begin
    expected_nxt = expected_r;
    window_nxt   = window_r;
    retries_nxt  = retries_r;
    draining_nxt = draining_r;
    bytes_nxt    = bytes_r;
    status_nxt   = status_r;
    copies_nxt   = ACK_NONE;
    ack_nxt      = '0;

    if (status_r == ST_RUNNING) begin
      if (q_cmd.kind == KIND_TIMEOUT) begin
        if (draining_r) begin
          // End of a drain: restart the window and, with a nonzero window size, re-ack the last good block.
          draining_nxt = 1'b0;
          window_nxt   = 17'd1;
          if (window_size != '0) begin
            copies_nxt = ACK_ONE;
            ack_nxt    = expected_r - 16'd1;
          end
        end else if (retries_r <= 8'd1) begin
          retries_nxt = '0;
          status_nxt  = ST_TIMEOUT;
        end else begin
          retries_nxt = retries_r - 8'd1;
        end
      end else if (!draining_r) begin
        retries_nxt = retry_limit;
        case (q_cmd.kind)
          KIND_DATA: begin
            if (q_cmd.blk == expected_r) begin
              bytes_nxt    = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
              expected_nxt = expected_r + 16'd1;
              if (window_r >= {1'b0, window_size} || q_cmd.is_short) begin
                copies_nxt = ACK_ONE;
                ack_nxt    = expected_r;
                window_nxt = 17'd1;
              end else begin
                window_nxt = window_r + 17'd1;
              end
              if (q_cmd.is_short) begin
                copies_nxt = ACK_FINAL;
                status_nxt = ST_COMPLETE;
              end
            end else begin
              draining_nxt = 1'b1;
            end
          end
          KIND_ERROR: status_nxt = ST_PEER_ERROR;
          default:    status_nxt = ST_UNEXPECTED;
        endcase
      end
    end

    if (!pop) begin
      expected_nxt = expected_r;
      window_nxt   = window_r;
      retries_nxt  = retries_r;
      draining_nxt = draining_r;
      bytes_nxt    = bytes_r;
      status_nxt   = status_r;
    end
    if (retry_reload) begin
      retries_nxt = retry_value;
    end

    out_valid_nxt = pop || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r  <= 16'd1;
      window_r    <= 17'd1;
      retries_r   <= RETRY_LIMIT_RST;
      draining_r  <= 1'b0;
      bytes_r     <= '0;
      status_r    <= ST_RUNNING;
      out_valid_r <= 1'b0;
    end else begin
      expected_r  <= expected_nxt;
      window_r    <= window_nxt;
      retries_r   <= retries_nxt;
      draining_r  <= draining_nxt;
      bytes_r     <= bytes_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The result register holds the outcome of the last event together with
  // the status and byte total that event left behind.
  always_ff @(posedge clk) begin
    if (pop) begin
      copies_r        <= copies_nxt;
      ack_r           <= ack_nxt;
      out_status      <= status_nxt;
      out_bytes_total <= bytes_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ack_copies = copies_r;
  assign out_ack_block  = ack_r;

endmodule

/* rtl/core/tftp_window_receiver_top.sv */
// Top level of the windowed TFTP receiver: configuration registers and block wiring.
// An accepted event is written into the event queue, and the result register loads its outcome
// when the back end pops it. Throughput: one event per cycle while the queue is not full and the
// result output is not stalled. A synchronous active-low reset restores the
// configuration defaults, empties the event queue and the result register, and returns the
// transfer to block one.
module tftp_window_receiver_top #(
  parameter int QUEUE_DEPTH = twr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [15:0] in_pkt_opcode,
  input  logic [15:0] in_pkt_block,
  input  logic [15:0] in_payload_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_ack_copies,
  output logic [15:0] out_ack_block,
  output logic [2:0]  out_status,
  output logic [31:0] out_bytes_total,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import twr_pkg::*;

  logic [15:0] block_size_r;
  logic [15:0] window_size_r;
  logic [7:0]  retry_limit_r;
  logic        retry_reload;
  logic        push;
  logic        full;
  logic        pop;
  logic        q_valid;
  cmd_t        front_cmd;
  cmd_t        q_cmd;

  assign retry_reload = cfg_we && (cfg_index == CFG_RETRY_LIMIT);
  assign in_stall     = full;
  assign push         = in_valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r  <= BLOCK_SIZE_RST;
      window_size_r <= WINDOW_SIZE_RST;
      retry_limit_r <= RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_SIZE:  block_size_r  <= cfg_wdata;
        CFG_WINDOW_SIZE: window_size_r <= cfg_wdata;
        CFG_RETRY_LIMIT: retry_limit_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  twr_front u_front (
    .in_func        (in_func),
    .in_pkt_opcode  (in_pkt_opcode),
    .in_pkt_block   (in_pkt_block),
    .in_payload_len (in_payload_len),
    .block_size     (block_size_r),
    .cmd            (front_cmd)
  );

  twr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (front_cmd),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  twr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .pop             (pop),
    .window_size     (window_size_r),
    .retry_limit     (retry_limit_r),
    .retry_reload    (retry_reload),
    .retry_value     (cfg_wdata[7:0]),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ack_copies  (out_ack_copies),
    .out_ack_block   (out_ack_block),
    .out_status      (out_status),
    .out_bytes_total (out_bytes_total)
  );

endmodule

/* verif/tb.sv */
// Self-checking testbench for the windowed TFTP receiver top level.
module tb;
  import twr_pkg::*;

  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_RUN_BLOCKS = 24;
  localparam logic [15:0] MAX_PAYLOAD = 16'd65464;

  typedef struct packed {
    logic        func;
    logic [15:0] opcode;
    logic [15:0] blk;
    logic [15:0] len;
  } rx_event_t;

  typedef struct packed {
    logic [1:0]  copies;
    logic [15:0] blk;
    status_t     status;
    logic [31:0] total;
  } ack_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_ack_copies;
  logic [15:0] out_ack_block;
  logic [2:0] out_status;
  logic [31:0] out_bytes_total;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_BLOCK_SIZE;
  logic [15:0] cfg_wdata = 16'd0;
  rx_event_t cur_event = '0;
  logic in_fired = 1'b0;

  rx_event_t events_pending[$];
  ack_rec_t acks_due[$];
  ack_rec_t due;
  int mismatches = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  // Receiver state as the testbench predicts it.
  logic [15:0] blk_bytes;
  logic [15:0] win_len;
  logic [7:0]  try_limit;
  logic [15:0] want_blk;
  logic [16:0] win_cnt;
  logic [7:0]  tries;
  logic        in_drain;
  logic [31:0] byte_sum;
  status_t     xfer_status;

  // Stimulus side view of the transfer, used only to keep it alive.
  logic [15:0] gen_blk;
  logic [15:0] gen_bs;
  int gen_rl;
  int tmo_budget;
  int gen_count = 0;

  tftp_window_receiver_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(cur_event.func),
    .in_pkt_opcode(cur_event.opcode),
    .in_pkt_block(cur_event.blk),
    .in_payload_len(cur_event.len),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_ack_copies(out_ack_copies),
    .out_ack_block(out_ack_block),
    .out_status(out_status),
    .out_bytes_total(out_bytes_total),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic ack_rec_t advance_transfer(input rx_event_t ev);
    ack_rec_t r;
    logic [15:0] size;
    logic [32:0] sum;
    logic short_blk;
    r.copies = ACK_NONE;
    r.blk = 16'd0;
    if (xfer_status == ST_RUNNING) begin
      if (ev.func) begin
        if (in_drain) begin
          in_drain = 1'b0;
          win_cnt = 17'd1;
          if (win_len != 16'd0) begin
            r.copies = ACK_ONE;
            r.blk = want_blk - 16'd1;
          end
        end else if (tries <= 8'd1) begin
          tries = 8'd0;
          xfer_status = ST_TIMEOUT;
        end else begin
          tries = tries - 8'd1;
        end
      end else if (!in_drain) begin
        tries = try_limit;
        if (ev.opcode == OP_DATA) begin
          if (ev.blk == want_blk) begin
            size = (ev.len > blk_bytes) ? blk_bytes : ev.len;
            short_blk = (size != blk_bytes);
            sum = {1'b0, byte_sum} + {17'd0, size};
            byte_sum = sum[32] ? 32'hffff_ffff : sum[31:0];
            if (win_cnt >= {1'b0, win_len} || short_blk) begin
              r.copies = ACK_ONE;
              r.blk = want_blk;
              win_cnt = 17'd1;
            end else begin
              win_cnt = win_cnt + 17'd1;
            end
            if (short_blk) begin
              r.copies = ACK_FINAL;
              xfer_status = ST_COMPLETE;
            end
            want_blk = want_blk + 16'd1;
          end else begin
            in_drain = 1'b1;
          end
        end else if (ev.opcode == OP_ERROR) begin
          xfer_status = ST_PEER_ERROR;
        end else begin
          xfer_status = ST_UNEXPECTED;
        end
      end
    end
    r.status = xfer_status;
    r.total = byte_sum;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("tb: %s mismatch: got %0h, expected %0h", what, got, want);
  endtask

  // Driver: a new event is presented only once the previous one has transferred.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (events_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur_event <= events_pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: register writes and accepted events update the prediction,
  // and every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    in_fired <= rst_n && in_valid && !in_stall;
    if (!rst_n) begin
      blk_bytes = BLOCK_SIZE_RST;
      win_len = WINDOW_SIZE_RST;
      try_limit = RETRY_LIMIT_RST;
      want_blk = 16'd1;
      win_cnt = 17'd1;
      tries = RETRY_LIMIT_RST;
      in_drain = 1'b0;
      byte_sum = 32'd0;
      xfer_status = ST_RUNNING;
      acks_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_SIZE: blk_bytes = cfg_wdata;
          CFG_WINDOW_SIZE: win_len = cfg_wdata;
          CFG_RETRY_LIMIT: begin
            try_limit = cfg_wdata[7:0];
            tries = cfg_wdata[7:0];
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        acks_due.push_back(advance_transfer(cur_event));
      end
      if (out_valid && !out_stall) begin
        if (acks_due.size() == 0) begin
          note_mismatch("extra result", 32'd1, 32'd0);
        end else begin
          due = acks_due.pop_front();
          if (out_ack_copies !== due.copies) begin
            note_mismatch("ack_copies", 32'(out_ack_copies), 32'(due.copies));
          end
          if (out_ack_block !== due.blk) begin
            note_mismatch("ack_block", 32'(out_ack_block), 32'(due.blk));
          end
          if (out_status !== due.status) begin
            note_mismatch("status", 32'(out_status), 32'(due.status));
          end
          if (out_bytes_total !== due.total) begin
            note_mismatch("bytes_total", out_bytes_total, due.total);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic push_event(input logic f, input logic [15:0] op, input logic [15:0] b,
                            input logic [15:0] l);
    rx_event_t ev;
    ev.func = f;
    ev.opcode = op;
    ev.blk = b;
    ev.len = l;
    events_pending.push_back(ev);
    gen_count++;
  endtask

  // In-order full blocks; any packet outside a drain restores the retry budget.
  task automatic send_blocks(input int n);
    for (int i = 0; i < n; i++) begin
      push_event(1'b0, OP_DATA, gen_blk, 16'($urandom_range(gen_bs, MAX_PAYLOAD)));
      gen_blk = gen_blk + 16'd1;
    end
    tmo_budget = gen_rl - 1;
  endtask

  // An out-of-order block, some discarded packets, then the timeout that resyncs.
  task automatic send_drain();
    int noise;
    noise = $urandom_range(0, 4);
    push_event(1'b0, OP_DATA, 16'(gen_blk + $urandom_range(1, 65535)),
               16'($urandom_range(0, MAX_PAYLOAD)));
    repeat (noise) push_event(1'b0, 16'($urandom), 16'($urandom),
                              16'($urandom_range(0, MAX_PAYLOAD)));
    push_event(1'b1, 16'($urandom), 16'($urandom), 16'($urandom_range(0, MAX_PAYLOAD)));
    tmo_budget = gen_rl - 1;
  endtask

  task automatic send_timeouts();
    int n;
    if (tmo_budget > 0) begin
      n = $urandom_range(1, tmo_budget);
      repeat (n) push_event(1'b1, 16'($urandom), 16'($urandom),
                            16'($urandom_range(0, MAX_PAYLOAD)));
      tmo_budget -= n;
    end
  endtask

  task automatic random_phase(input int n);
    int start;
    int pick;
    start = gen_count;
    while (gen_count - start < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_blocks($urandom_range(1, 6));
      end else if (pick < 80) begin
        send_drain();
      end else if (tmo_budget > 0) begin
        send_timeouts();
      end else begin
        send_blocks(1);
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (events_pending.size() != 0 || in_valid || acks_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BLOCK_SIZE) begin
      gen_bs = val;
    end else if (idx == CFG_RETRY_LIMIT) begin
      gen_rl = 32'(val[7:0]);
      tmo_budget = gen_rl - 1;
    end
  endtask

  task automatic configure(input logic [15:0] bs, input logic [15:0] ws, input logic [7:0] rl,
                           input int send_idle, input int rx_stall);
    logic [7:0] junk;
    junk = 8'($urandom);
    wait_idle();
    set_reg(CFG_BLOCK_SIZE, bs);
    set_reg(CFG_WINDOW_SIZE, ws);
    // The upper byte of a retry limit write is not part of the register.
    set_reg(CFG_RETRY_LIMIT, {junk, rl});
    idle_pct = send_idle;
    stall_pct = rx_stall;
  endtask

  initial begin
    logic [15:0] odd_op;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    gen_bs = BLOCK_SIZE_RST;
    gen_rl = 32'(RETRY_LIMIT_RST);

    // Directed opening with the reset configuration.
    push_event(1'b0, OP_DATA, 16'd1, 16'd512);
    push_event(1'b0, OP_DATA, 16'd2, MAX_PAYLOAD);
    push_event(1'b1, 16'hffff, 16'hffff, MAX_PAYLOAD);
    push_event(1'b1, 16'd0, 16'd0, 16'd0);
    push_event(1'b0, OP_DATA, 16'd3, 16'd513);
    push_event(1'b0, OP_DATA, 16'hffff, 16'd0);
    push_event(1'b0, OP_ERROR, 16'd4, 16'd0);
    push_event(1'b0, 16'hffff, 16'hffff, MAX_PAYLOAD);
    push_event(1'b0, 16'd0, 16'd0, 16'd0);
    push_event(1'b0, OP_DATA, 16'd4, 16'd512);
    push_event(1'b1, 16'd0, 16'd0, 16'd0);
    push_event(1'b0, OP_DATA, 16'd4, 16'd600);
    gen_blk = 16'd5;
    tmo_budget = gen_rl - 1;

    // Shrinking the window below the running count forces an ACK on the next block.
    wait_idle();
    set_reg(CFG_WINDOW_SIZE, 16'd65535);
    send_blocks(3);
    wait_idle();
    set_reg(CFG_WINDOW_SIZE, 16'd2);
    set_reg(CFG_UNUSED_IDX, 16'hffff);
    send_blocks(1);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: configure(16'd8, 16'd0, 8'd255, 0, 0);
        1: configure(MAX_PAYLOAD, 16'd65535, 8'd1, 80, 0);
        2: configure(16'($urandom_range(8, 1500)), 16'd1, 8'($urandom_range(2, 10)), 0, 80);
        3: configure(16'($urandom_range(8, MAX_PAYLOAD)), 16'($urandom_range(2, 8)), 8'd3,
                     37, 37);
        4: configure(16'd8, 16'd2, 8'd255, 0, 0);
        5: configure(16'($urandom_range(8, 4000)), 16'd0, 8'($urandom_range(1, 255)), 80, 0);
        6: configure(16'($urandom_range(8, 100)), 16'($urandom_range(3, 20)),
                     8'($urandom_range(1, 5)), 0, 80);
        default: configure(16'($urandom_range(8, MAX_PAYLOAD)), 16'($urandom),
                           8'($urandom_range(1, 255)), 37, 37);
      endcase
      random_phase(170);
    end

    // A closing run of maximum-size blocks under a wide window.
    configure(MAX_PAYLOAD, 16'd65535, 8'd255, 0, 0);
    for (int i = 0; i < LONG_RUN_BLOCKS; i++) begin
      if (gen_blk == 16'd0) begin
        send_drain();
      end
      send_blocks(1);
    end

    // End the transfer one way or another, then show that later events are ignored.
    case ($urandom_range(0, 3))
      0: push_event(1'b0, OP_DATA, gen_blk, 16'($urandom_range(0, gen_bs - 1)));
      1: push_event(1'b0, OP_ERROR, 16'($urandom), 16'($urandom_range(0, MAX_PAYLOAD)));
      2: begin
        odd_op = 16'($urandom);
        if (odd_op == OP_DATA || odd_op == OP_ERROR) begin
          odd_op = 16'hfffe;
        end
        push_event(1'b0, odd_op, 16'($urandom), 16'($urandom_range(0, MAX_PAYLOAD)));
      end
      default: begin
        repeat (tmo_budget + 1) push_event(1'b1, 16'($urandom), 16'($urandom), 16'd0);
      end
    endcase
    repeat (20) push_event(1'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom_range(0, MAX_PAYLOAD)));

    wait_idle();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
